// ===== rtl/ccwd_pkg.sv =====
// shared types and constants for the cumulative count window delta block
`default_nettype none

package ccwd_pkg;

    // ring geometry
    localparam int CAPACITY = 64;
    localparam int CELLS    = CAPACITY + 1;
    localparam int PTR_W    = $clog2(CELLS);

    // field widths
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;
    localparam int OFF_W    = 16;
    localparam int FRAC_W   = 8;
    localparam int AVG_W    = DATA_W + FRAC_W;
    localparam int STEP_W   = $clog2(AVG_W);

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ORDER = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_RESET,
        CMD_DELTA,
        CMD_AVG
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic [DATA_W-1:0]  sample_count;
        logic [OFF_W-1:0]   back_from;
        logic [OFF_W-1:0]   back_to;
        logic [OFF_W-1:0]   window_len;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  delta;
        logic [AVG_W-1:0]   average;
        logic [CNT_W-1:0]   filled;
        logic               significant;
        logic               status;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ccwd_ram.sv =====
// count ring storage: one write port, one read port with registered data
`default_nettype none

module ccwd_ram (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [ccwd_pkg::PTR_W-1:0]  waddr,
    input  wire logic [ccwd_pkg::DATA_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [ccwd_pkg::PTR_W-1:0]  raddr,
    output logic      [ccwd_pkg::DATA_W-1:0] rdata
);
    import ccwd_pkg::*;

    logic [DATA_W-1:0] mem [CELLS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data registered on the read enable
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ccwd_div.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none

module ccwd_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ccwd_pkg::AVG_W-1:0] dividend,
    input  wire logic [ccwd_pkg::CNT_W-1:0] divisor,
    output logic                            done,
    output logic      [ccwd_pkg::AVG_W-1:0] quotient
);
    import ccwd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [AVG_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W:0]    rem_sh;
    logic              fits;

    // one trial subtraction
    always_comb
    begin
        rem_sh = {rem_reg, q_reg[AVG_W-1]};
        fits   = (rem_sh >= {1'b0, divisor});
    end

    // next state
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(AVG_W - 1);
            q_next    = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
            q_next   = {q_reg[AVG_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    // no step is taken when idle and a finished division leaves the unit idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

`default_nettype wire

// ===== rtl/cumulative_count_window_delta_top.sv =====
// windowed rate meter over a ring of cumulative counts: sequencer and top level
// add and reset requests complete at the accept edge and leave the block ready for the next request
// delta query: runs S_RD_NEW, S_RD_OLD, S_CAP_OLD and S_DONE (two ring reads through one read port)
// average query with a nonzero window: adds S_DIV_GO and S_DIV around the 40-step serial divider
// one request is processed at a time; a waiting result does not block the next accept
// async reset empties the ring, clears the write position and makes the base cell read zero
`default_nettype none

module cumulative_count_window_delta_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ccwd_pkg::req_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ccwd_pkg::rsp_t      out_data
);
    import ccwd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_NEW,
        S_RD_OLD,
        S_CAP_OLD,
        S_DIV_GO,
        S_DIV,
        S_DONE
    } state_t;

    // control registers
    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]  filled_reg, filled_next;
    logic              base_valid_reg, base_valid_next;
    logic              rd_zero_reg, rd_zero_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic [CNT_W-1:0]  off_new_reg, off_new_next;
    logic [CNT_W-1:0]  off_old_reg, off_old_next;
    logic              is_avg_reg, is_avg_next;
    logic              zero_reg, zero_next;
    logic              status_reg, status_next;
    logic              signif_reg, signif_next;
    logic [DATA_W-1:0] new_val_reg, new_val_next;
    logic [DATA_W-1:0] delta_reg, delta_next;
    logic [AVG_W-1:0]  avg_reg, avg_next;
    rsp_t              out_reg, out_next;

    logic              in_fire;
    logic              mem_we, mem_re;
    logic [PTR_W-1:0]  mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_rdata, rd_val;
    logic [CNT_W-1:0]  clamp_to, clamp_from, clamp_win, off_sel;
    logic [PTR_W:0]    idx_sum;
    logic              div_start, div_done;
    logic [AVG_W-1:0]  div_quot;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // offsets clamped to the fill
    always_comb
    begin
        clamp_to   = (in_data.back_to < OFF_W'(filled_reg)) ?
                     in_data.back_to[CNT_W-1:0] : filled_reg;
        clamp_from = (in_data.back_from < OFF_W'(filled_reg)) ?
                     in_data.back_from[CNT_W-1:0] : filled_reg;
        clamp_win  = (in_data.window_len < OFF_W'(filled_reg)) ?
                     in_data.window_len[CNT_W-1:0] : filled_reg;
    end

    // look-back cell index: write position minus one minus offset, modulo ring size
    always_comb
    begin
        off_sel   = (state_reg == S_RD_NEW) ? off_new_reg : off_old_reg;
        idx_sum   = (PTR_W+1)'(wp_reg) + (PTR_W+1)'(CELLS - 1) - (PTR_W+1)'(off_sel);
        mem_raddr = (idx_sum >= (PTR_W+1)'(CELLS)) ?
                    PTR_W'(idx_sum - (PTR_W+1)'(CELLS)) : idx_sum[PTR_W-1:0];
        mem_re    = (state_reg == S_RD_NEW) || (state_reg == S_RD_OLD);
    end

    // ring writes happen at the accept edge of add and reset
    always_comb
    begin
        mem_we    = in_fire && ((in_data.command == CMD_ADD) ||
                                (in_data.command == CMD_RESET));
        mem_waddr = (in_data.command == CMD_ADD) ? wp_reg : PTR_W'(CAPACITY);
    end

    // base cell reads as zero until written
    assign rd_val    = rd_zero_reg ? '0 : mem_rdata;
    assign div_start = (state_reg == S_DIV_GO);

    ccwd_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (in_data.sample_count),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ccwd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({delta_reg, FRAC_W'(0)}),
        .divisor  (off_old_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        filled_next     = filled_reg;
        base_valid_next = base_valid_reg;
        rd_zero_next    = mem_re && (mem_raddr == PTR_W'(CAPACITY)) && !base_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        off_new_next    = off_new_reg;
        off_old_next    = off_old_reg;
        is_avg_next     = is_avg_reg;
        zero_next       = zero_reg;
        status_next     = status_reg;
        signif_next     = signif_reg;
        new_val_next    = new_val_reg;
        delta_next      = delta_reg;
        avg_next        = avg_reg;
        out_next        = out_reg;

        if (mem_we && (mem_waddr == PTR_W'(CAPACITY)))
        begin
            base_valid_next = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    signif_next = (OFF_W'(filled_reg) >= in_data.window_len);
                    case (in_data.command)
                        CMD_ADD:
                        begin
                            wp_next = (wp_reg == PTR_W'(CELLS - 1)) ? '0 : wp_reg + 1'b1;
                            if (filled_reg < CNT_W'(CAPACITY))
                            begin
                                filled_next = filled_reg + 1'b1;
                            end
                        end
                        CMD_RESET:
                        begin
                            wp_next     = '0;
                            filled_next = '0;
                        end
                        CMD_DELTA:
                        begin
                            off_new_next = clamp_to;
                            off_old_next = clamp_from;
                            is_avg_next  = 1'b0;
                            zero_next    = (in_data.back_to > in_data.back_from);
                            status_next  = (in_data.back_to > in_data.back_from) ?
                                           STATUS_ORDER : STATUS_OK;
                            state_next   = S_RD_NEW;
                        end
                        CMD_AVG:
                        begin
                            off_new_next = '0;
                            off_old_next = clamp_win;
                            is_avg_next  = 1'b1;
                            zero_next    = (clamp_win == '0);
                            status_next  = STATUS_OK;
                            state_next   = S_RD_NEW;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_NEW:
            begin
                state_next = S_RD_OLD;
            end
            S_RD_OLD:
            begin
                new_val_next = rd_val;
                state_next   = S_CAP_OLD;
            end
            S_CAP_OLD:
            begin
                delta_next = zero_reg ? '0 : new_val_reg - rd_val;
                avg_next   = '0;
                state_next = (is_avg_reg && !zero_reg) ? S_DIV_GO : S_DONE;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = div_quot;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.delta       = delta_reg;
                    out_next.average     = avg_reg;
                    out_next.filled      = filled_reg;
                    out_next.significant = signif_reg;
                    out_next.status      = status_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wp_reg         <= '0;
            filled_reg     <= '0;
            base_valid_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            filled_reg     <= filled_next;
            base_valid_reg <= base_valid_next;
            rd_zero_reg    <= rd_zero_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        off_new_reg <= off_new_next;
        off_old_reg <= off_old_next;
        is_avg_reg  <= is_avg_next;
        zero_reg    <= zero_next;
        status_reg  <= status_next;
        signif_reg  <= signif_next;
        new_val_reg <= new_val_next;
        delta_reg   <= delta_next;
        avg_reg     <= avg_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // fill count grows by one per added sample and stops at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.command == CMD_ADD)) |=>
        (filled_reg == (($past(filled_reg) == CNT_W'(CAPACITY)) ?
                        $past(filled_reg) : $past(filled_reg) + 1'b1)))
        else $error("fill count not advanced by add");

    // reset request empties the ring and marks the base cell written
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.command == CMD_RESET)) |=>
        ((wp_reg == '0) && (filled_reg == '0) && base_valid_reg))
        else $error("reset request did not clear ring state");

    // the divider never sees a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (off_old_reg != '0))
        else $error("division started with empty window");

    // a new result is only loaded from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside done state");

    // ring is only written between queries
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE))
        else $error("ring written during a query");

endmodule

`default_nettype wire

// ===== bench/tb_cumulative_count_window_delta_top.sv =====
// self-checking testbench for the cumulative count window delta block
`timescale 1ns / 100ps

module tb_cumulative_count_window_delta_top;

    import ccwd_pkg::*;

    localparam int unsigned ITEM_TARGET = 1400;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned SETTLE      = 60;

    // prediction of the rate meter and store of awaited results
    class window_meter_model;
        logic [DATA_W-1:0] counts [0:CELLS-1];
        int unsigned       wpos;
        int unsigned       fill;
        rsp_t              awaited_results [$];
        int unsigned       errors;

        function new();
            foreach (counts[i]) counts[i] = '0;
            wpos   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        // stored count a number of samples back, clamped to the fill
        function logic [DATA_W-1:0] count_back(int unsigned back);
            int unsigned b;
            b = (back < fill) ? back : fill;
            return counts[(wpos + CELLS - 1 - b) % CELLS];
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        // update state for an accepted request, queue any result it causes
        function void take_request(req_t r);
            rsp_t              e;
            int unsigned       n;
            logic [DATA_W-1:0] d;
            logic [63:0]       q;
            e = '0;
            case (r.command)
                CMD_ADD:
                begin
                    counts[wpos] = r.sample_count;
                    wpos = (wpos + 1) % CELLS;
                    if (fill < CAPACITY)
                        fill++;
                end
                CMD_RESET:
                begin
                    counts[CAPACITY] = r.sample_count;
                    wpos = 0;
                    fill = 0;
                end
                CMD_DELTA:
                begin
                    if (r.back_to > r.back_from)
                        e.status = STATUS_ORDER;
                    else
                        e.delta = count_back(r.back_to) - count_back(r.back_from);
                end
                CMD_AVG:
                begin
                    n = (r.window_len < fill) ? r.window_len : fill;
                    if (n != 0)
                    begin
                        d = count_back(0) - count_back(n);
                        q = {24'd0, d, 8'd0} / n;
                        e.delta   = d;
                        e.average = q[AVG_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
            if (r.command == CMD_DELTA || r.command == CMD_AVG)
            begin
                e.filled      = fill[CNT_W-1:0];
                e.significant = (fill >= r.window_len);
                awaited_results.push_back(e);
            end
        endfunction

        // compare one returned result with the oldest awaited one
        function void check_result(rsp_t got);
            rsp_t e;
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: delta %h average %h", got.delta, got.average);
                errors++;
                return;
            end
            e = awaited_results.pop_front();
            if (got.delta !== e.delta)
            begin
                $error("delta: expected %h, got %h", e.delta, got.delta);
                errors++;
            end
            if (got.average !== e.average)
            begin
                $error("average: expected %h, got %h", e.average, got.average);
                errors++;
            end
            if (got.filled !== e.filled)
            begin
                $error("filled: expected %0d, got %0d", e.filled, got.filled);
                errors++;
            end
            if (got.significant !== e.significant)
            begin
                $error("significant: expected %b, got %b", e.significant, got.significant);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %b, got %b", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    rsp_t out_data;

    window_meter_model meter = new();
    int unsigned       sent;
    int unsigned       idle_cycles = 0;
    logic              calm;
    logic [31:0]       running;

    cumulative_count_window_delta_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        else if (p < 85)
            return $urandom_range(1, 3);
        else if (p < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // look-back offset, mostly in 0 to 70, now and then anywhere in the 16-bit range
    function automatic logic [OFF_W-1:0] offset_pick();
        if ($urandom_range(0, 3) == 0)
            return OFF_W'($urandom_range(0, 65535));
        else
            return OFF_W'($urandom_range(0, 70));
    endfunction

    // present one request and hold it until accepted
    task automatic issue(cmd_t c, logic [DATA_W-1:0] s, logic [OFF_W-1:0] f,
                         logic [OFF_W-1:0] t, logic [OFF_W-1:0] w);
        req_t        r;
        int unsigned g;
        r.command      = c;
        r.sample_count = s;
        r.back_from    = f;
        r.back_to      = t;
        r.window_len   = w;
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        meter.take_request(r);
        sent++;
        g = calm ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // hold off the sender until every awaited result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (meter.pending() != 0)
            @(posedge clk);
    endtask

    // one random request, weighted towards adds and well-ordered queries
    task automatic random_item();
        int unsigned       p;
        logic [OFF_W-1:0]  f;
        logic [OFF_W-1:0]  t;
        p = $urandom_range(0, 99);
        f = offset_pick();
        t = ($urandom_range(0, 9) == 0) ? offset_pick() : OFF_W'($urandom_range(0, f));
        if (p < 45)
        begin
            if ($urandom_range(0, 19) == 0)
                running = $urandom;
            else
                running = running + $urandom_range(0, 1000);
            issue(CMD_ADD, running, OFF_W'($urandom_range(0, 65535)),
                  OFF_W'($urandom_range(0, 65535)), OFF_W'($urandom_range(0, 65535)));
        end
        else if (p < 75)
            issue(CMD_DELTA, $urandom, f, t, offset_pick());
        else
            issue(CMD_AVG, $urandom, f, t, offset_pick());
    endtask

    // result side back-pressure
    initial
    begin : result_sink
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (calm || $urandom_range(0, 99) < 60)
            begin
                out_ready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            meter.check_result(out_data);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int unsigned seg_len;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        calm        = 1'b0;
        sent        = 0;
        running     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, zero window and out-of-order offsets
        issue(CMD_AVG,   32'h0, 16'd0, 16'd0, 16'd5);
        issue(CMD_AVG,   32'h0, 16'd0, 16'd0, 16'd0);
        issue(CMD_DELTA, 32'h0, 16'd0, 16'd0, 16'd0);
        issue(CMD_DELTA, 32'h0, 16'd3, 16'd7, 16'd1);
        // base at the top of the range so the first delta wraps
        issue(CMD_RESET, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
        issue(CMD_ADD,   32'h0000_0005, 16'd0, 16'd0, 16'd0);
        issue(CMD_DELTA, 32'h0, 16'd1, 16'd0, 16'd1);
        issue(CMD_ADD,   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        issue(CMD_ADD,   32'h0000_0000, 16'd0, 16'd0, 16'd0);
        issue(CMD_DELTA, 32'h0, 16'd1, 16'd0, 16'd2);
        // offsets far beyond the fill are clamped
        issue(CMD_DELTA, 32'h0, 16'hFFFF, 16'd0, 16'd3);
        issue(CMD_DELTA, 32'h0, 16'hFFFF, 16'hFFFF, 16'd4);
        issue(CMD_DELTA, 32'h0, 16'd0, 16'hFFFF, 16'd0);
        issue(CMD_AVG,   32'h0, 16'd0, 16'd0, 16'hFFFF);
        issue(CMD_AVG,   32'h0, 16'd0, 16'd0, 16'd1);
        issue(CMD_AVG,   32'h0, 16'd0, 16'd0, 16'd3);
        issue(CMD_ADD,   32'hA5A5_5A5A, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        issue(CMD_AVG,   32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd2);
        issue(CMD_RESET, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        issue(CMD_AVG,   32'h0, 16'd0, 16'd0, 16'd1);
        drain();

        // random segments, most starting from a fresh base
        while (sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0)
            begin
                running = $urandom;
                issue(CMD_RESET, running, OFF_W'($urandom_range(0, 65535)),
                      OFF_W'($urandom_range(0, 65535)), OFF_W'($urandom_range(0, 65535)));
            end
            seg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(10, 80);
            repeat (seg_len) random_item();
            if ($urandom_range(0, 4) == 0)
                drain();
        end

        // wind down
        calm = 1'b0;
        drain();
        repeat (SETTLE) @(posedge clk);
        if (meter.pending() == 0 && meter.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ccwd_pkg.sv
rtl/ccwd_ram.sv
rtl/ccwd_div.sv
rtl/cumulative_count_window_delta_top.sv
bench/tb_cumulative_count_window_delta_top.sv
